// ----- hdl/line_centroid_nonlinear_pd_steer_core_assert.svh -----
// Assertion macros shared by the steering core.
`ifndef LINE_CENTROID_NONLINEAR_PD_STEER_CORE_ASSERT_SVH
`define LINE_CENTROID_NONLINEAR_PD_STEER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCPS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("steering core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LCPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("steering core assertion failed");

`endif

// ----- hdl/lcps_pkg.sv -----
`timescale 1ns / 1ps

package lcps_pkg;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_SENSOR_WEIGHTS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_PROP      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_DERIV     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_SPEED     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_LIMIT    = 3'd4;

   localparam int MUL_A_W   = 16;
   localparam int MUL_B_W   = 15;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int DIV_NUM_W = 22;
   localparam int DIV_DEN_W = 4;
   localparam int CORR_W    = 24;
   localparam int Q_SHIFT   = 8;

   localparam logic [DIV_DEN_W-1:0] P_DIVISOR = 4'd7;

   function automatic logic [15:0] sat_speed(input logic signed [CORR_W-1:0] v,
                                             input logic [14:0] lim);
      logic signed [CORR_W-1:0] lim_pos;
      logic signed [CORR_W-1:0] lim_neg;
      logic signed [CORR_W-1:0] r;
      lim_pos = $signed(CORR_W'(lim));
      lim_neg = -lim_pos;
      if (v > lim_pos) begin
         r = lim_pos;
      end else if (v < lim_neg) begin
         r = lim_neg;
      end else begin
         r = v;
      end
      return r[15:0];
   endfunction

endpackage

// ----- hdl/line_centroid_nonlinear_pd_steer_core.sv -----
// Channel | Direction | Ports                            | Word
// req     | in        | req_tvalid/tready/tdata/tuser    | tdata: sensor_hits; tuser: cmd
// rsp     | out       | rsp_tvalid/tready/tdata          | left, right, line error
// csr     | in        | csr_valid/ready/index/data       | one register write
//
// A sample word runs the one-sensor-per-cycle scan, the 15-step shift-add multiplier
// (used three times) and the 22-step restoring divider (used twice, or once when no
// sensor or every sensor is hit); a clear word produces no result.
// Reset is synchronous and restores the register defaults and zero error state.
// A finished result waits in the output register; a new word is accepted meanwhile.
`timescale 1ns / 1ps
`include "line_centroid_nonlinear_pd_steer_core_assert.svh"

module line_centroid_nonlinear_pd_steer_core #(
   parameter int SENSOR_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] sensor_hits
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] left_target, [31:16] right_target,
                                    // [39:32] line_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [lcps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0] csr_data
);

   localparam int IDX_W = $clog2(SENSOR_COUNT);
   localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
   localparam int SUM_W = 8 + CNT_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SCAN = 4'd1;
   localparam logic [3:0] ST_EVAL = 4'd2;
   localparam logic [3:0] ST_DIVE = 4'd3;
   localparam logic [3:0] ST_SQGO = 4'd4;
   localparam logic [3:0] ST_SQ   = 4'd5;
   localparam logic [3:0] ST_KP   = 4'd6;
   localparam logic [3:0] ST_P7   = 4'd7;
   localparam logic [3:0] ST_CORR = 4'd8;
   localparam logic [3:0] ST_FIN  = 4'd9;

   logic [63:0] weights_ff;
   logic [15:0] kp_ff, kd_ff, base_ff;
   logic [14:0] limit_ff;

   logic [3:0]  state_ff, state_in;
   logic [7:0]  hits_sh_ff, hits_sh_in;
   logic [63:0] wts_sh_ff, wts_sh_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [7:0]  held_error_ff, held_error_in;
   logic [7:0]  prev_error_ff, prev_error_in;
   logic        dsign_ff, dsign_in;
   logic signed [lcps_pkg::CORR_W-1:0] pterm_ff, pterm_in;
   logic signed [lcps_pkg::CORR_W-1:0] dterm_ff, dterm_in;
   logic signed [lcps_pkg::CORR_W-1:0] corr_ff, corr_in;
   logic [39:0] rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        mul_start, div_start;
   logic [lcps_pkg::MUL_A_W-1:0]   mul_a;
   logic [lcps_pkg::MUL_B_W-1:0]   mul_b;
   logic [lcps_pkg::MUL_P_W-1:0]   mul_prod;
   logic [lcps_pkg::DIV_NUM_W-1:0] div_num, div_quo;
   logic [lcps_pkg::DIV_DEN_W-1:0] div_den;
   lcps_pkg::unit_status_type      mul_stat, div_stat;

   logic [SUM_W-1:0] sum_mag;
   logic [SUM_W-1:0] w_ext;
   logic [7:0]  e_mag;
   logic [8:0]  diff, diff_mag;
   logic [15:0] kp_mag, kd_mag;
   logic [7:0]  q8;
   logic signed [lcps_pkg::CORR_W-1:0] base_ext, left_v, right_v, p_mag, d_mag;
   logic        psign;

   lcps_mul #(
      .A_W(lcps_pkg::MUL_A_W),
      .B_W(lcps_pkg::MUL_B_W)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .product(mul_prod),
      .status (mul_stat)
   );

   lcps_div #(
      .NUM_W(lcps_pkg::DIV_NUM_W),
      .DEN_W(lcps_pkg::DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .status(div_stat)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign w_ext    = {{(SUM_W-8){wts_sh_ff[7]}}, wts_sh_ff[7:0]};
   assign sum_mag  = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign e_mag    = held_error_ff[7] ? (~held_error_ff + 1'b1) : held_error_ff;
   assign diff     = {held_error_ff[7], held_error_ff} - {prev_error_ff[7], prev_error_ff};
   assign diff_mag = diff[8] ? (~diff + 1'b1) : diff;
   assign kp_mag   = kp_ff[15] ? (~kp_ff + 1'b1) : kp_ff;
   assign kd_mag   = kd_ff[15] ? (~kd_ff + 1'b1) : kd_ff;
   assign q8       = div_quo[7:0];
   assign psign    = kp_ff[15] ^ held_error_ff[7];
   assign p_mag    = $signed(lcps_pkg::CORR_W'(div_quo));
   assign d_mag    = $signed(lcps_pkg::CORR_W'(mul_prod[lcps_pkg::Q_SHIFT +: 15]));
   assign base_ext = $signed({{(lcps_pkg::CORR_W-16){base_ff[15]}}, base_ff});
   assign left_v   = base_ext + corr_ff;
   assign right_v  = base_ext - corr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff <= '0;
         kp_ff      <= 16'd256;
         kd_ff      <= '0;
         base_ff    <= '0;
         limit_ff   <= 15'h7FFF;
      end else if (csr_valid) begin
         case (csr_index)
            lcps_pkg::REG_SENSOR_WEIGHTS: weights_ff <= csr_data;
            lcps_pkg::REG_GAIN_PROP:      kp_ff      <= csr_data[15:0];
            lcps_pkg::REG_GAIN_DERIV:     kd_ff      <= csr_data[15:0];
            lcps_pkg::REG_BASE_SPEED:     base_ff    <= csr_data[15:0];
            lcps_pkg::REG_SPEED_LIMIT:    limit_ff   <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      hits_sh_in    = hits_sh_ff;
      wts_sh_in     = wts_sh_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      held_error_in = held_error_ff;
      prev_error_in = prev_error_ff;
      dsign_in      = dsign_ff;
      pterm_in      = pterm_ff;
      dterm_in      = dterm_ff;
      corr_in       = corr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      mul_start     = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  held_error_in = '0;
                  prev_error_in = '0;
               end else begin
                  hits_sh_in = req_tdata;
                  wts_sh_in  = weights_ff;
                  idx_in     = '0;
                  cnt_in     = '0;
                  sum_in     = '0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hits_sh_ff[0]) begin
               sum_in = sum_ff + w_ext;
               cnt_in = cnt_ff + 1'b1;
            end
            hits_sh_in = {1'b0, hits_sh_ff[7:1]};
            wts_sh_in  = {8'h00, wts_sh_ff[63:8]};
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(SENSOR_COUNT - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (cnt_ff == '0) begin
               state_in = ST_SQGO;
            end else if (cnt_ff == CNT_W'(SENSOR_COUNT)) begin
               held_error_in = '0;
               state_in      = ST_SQGO;
            end else begin
               div_start = 1'b1;
               div_num   = lcps_pkg::DIV_NUM_W'(sum_mag);
               div_den   = lcps_pkg::DIV_DEN_W'(cnt_ff);
               state_in  = ST_DIVE;
            end
         end
         ST_DIVE: begin
            if (div_stat.done) begin
               held_error_in = sum_ff[SUM_W-1] ? (~q8 + 1'b1) : q8;
               state_in      = ST_SQGO;
            end
         end
         ST_SQGO: begin
            mul_start = 1'b1;
            mul_a     = lcps_pkg::MUL_A_W'(e_mag);
            mul_b     = lcps_pkg::MUL_B_W'(e_mag);
            state_in  = ST_SQ;
         end
         ST_SQ: begin
            if (mul_stat.done) begin
               mul_start = 1'b1;
               mul_a     = kp_mag;
               mul_b     = mul_prod[lcps_pkg::MUL_B_W-1:0];
               state_in  = ST_KP;
            end
         end
         ST_KP: begin
            if (mul_stat.done) begin
               div_start     = 1'b1;
               div_num       = mul_prod[lcps_pkg::Q_SHIFT +: lcps_pkg::DIV_NUM_W];
               div_den       = lcps_pkg::P_DIVISOR;
               mul_start     = 1'b1;
               mul_a         = kd_mag;
               mul_b         = lcps_pkg::MUL_B_W'(diff_mag[7:0]);
               dsign_in      = kd_ff[15] ^ diff[8];
               prev_error_in = held_error_ff;
               state_in      = ST_P7;
            end
         end
         ST_P7: begin
            if (mul_stat.done) begin
               dterm_in = dsign_ff ? -d_mag : d_mag;
            end
            if (div_stat.done) begin
               pterm_in = psign ? -p_mag : p_mag;
               state_in = ST_CORR;
            end
         end
         ST_CORR: begin
            corr_in  = pterm_ff + dterm_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {held_error_ff,
                               lcps_pkg::sat_speed(right_v, limit_ff),
                               lcps_pkg::sat_speed(left_v, limit_ff)};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hits_sh_ff  <= hits_sh_in;
      wts_sh_ff   <= wts_sh_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      dsign_ff    <= dsign_in;
      pterm_ff    <= pterm_in;
      dterm_ff    <= dterm_in;
      corr_ff     <= corr_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_error_ff <= '0;
         prev_error_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_error_ff <= held_error_in;
         prev_error_ff <= prev_error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   `LCPS_ASSERT_NEXT(a_clear_zeroes_errors, clock, reset, req_tvalid && req_tready && req_tuser, held_error_ff == 8'd0 && prev_error_ff == 8'd0)
   `LCPS_ASSERT_NOW(a_dterm_before_pterm, clock, reset, div_stat.done && state_ff == ST_P7, !mul_stat.busy)
   `LCPS_ASSERT_NOW(a_units_start_idle, clock, reset, mul_start || div_start, !(mul_start && mul_stat.busy) && !(div_start && div_stat.busy))
   `LCPS_ASSERT_NEXT(a_fin_delivers, clock, reset, state_ff == ST_FIN && (!rsp_tvalid || rsp_tready), rsp_tvalid && state_ff == ST_IDLE)

endmodule

// ----- hdl/lcps_mul.sv -----
`timescale 1ns / 1ps

module lcps_mul #(
   parameter int A_W = 16,
   parameter int B_W = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [A_W-1:0]         a,
   input  logic [B_W-1:0]         b,
   output logic [A_W+B_W-1:0]     product,
   output lcps_pkg::unit_status_type status
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W+B_W-1:0] acc_ff, acc_in;
   logic [A_W-1:0]     a_ff, a_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [A_W:0]       part_sum;

   assign part_sum = {1'b0, acc_ff[A_W+B_W-1:B_W]} + (acc_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = {{A_W{1'b0}}, b};
         a_in    = a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {part_sum, acc_ff[B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- hdl/lcps_div.sv -----
`timescale 1ns / 1ps

module lcps_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic [NUM_W-1:0]     quo,
   output lcps_pkg::unit_status_type status
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W+1:0] trial;
   logic             fits;

   assign trial = {1'b0, rem_ff, quo_ff[NUM_W-1]} - {2'b00, den_ff};
   assign fits  = ~trial[DEN_W+1];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? trial[DEN_W-1:0] : {rem_ff[DEN_W-2:0], quo_ff[NUM_W-1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo         = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
